// File: src/lkvc_pkg.sv
package lkvc_pkg;

    localparam int Capacity  = 16;
    localparam int SlotBits  = 4;
    localparam int CountBits = 5;
    localparam int KeyBits   = 64;
    localparam int ValueBits = 64;
    localparam logic [CountBits-1:0] LimitReset = 5'd16;

    typedef enum logic [1:0] {
        CMD_SET  = 2'd0,
        CMD_GET  = 2'd1,
        CMD_PEEK = 2'd2,
        CMD_DUMP = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVICT,
        ST_WRITE,
        ST_LOOK,
        ST_DUMP_SCAN,
        ST_DUMP_EMIT,
        ST_OUT_WAIT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;       // capture input word
        logic evict;      // evict least recent if over bound
        logic write;      // set: update or insert
        logic touch;      // get hit: make most recent
        logic look_out;   // load lookup result into output register
        logic dump_start; // clear sent marks, reset scan index
        logic dump_step;  // compare one slot for the running minimum
        logic dump_emit;  // load dump result into output register
        logic out_take;   // output register consumed
    } t_ctrl;

    // datapath to controller
    typedef struct packed {
        logic    [1:0] cmd;
        logic          hit;
        logic          scan_done;
        logic          found_any;
        logic          more_left;
        logic          empty;
        logic          out_full;
    } t_stat;

endpackage

// File: src/lkvc_ctrl.sv
module lkvc_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  logic           i_out_ready,
    input  lkvc_pkg::t_stat i_stat,
    output lkvc_pkg::t_ctrl o_ctrl
);

    lkvc_pkg::t_state r_state, n_state;
    logic w_out_take;

    assign w_out_take = i_stat.out_full && i_out_ready;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lkvc_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lkvc_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = lkvc_pkg::ST_LOOK;
                end
            end
            lkvc_pkg::ST_LOOK: begin
                unique case (i_stat.cmd)
                    lkvc_pkg::CMD_SET: n_state = lkvc_pkg::ST_EVICT;
                    lkvc_pkg::CMD_DUMP: begin
                        if (!i_stat.out_full || i_out_ready) begin
                            n_state = i_stat.empty ? lkvc_pkg::ST_IDLE
                                                   : lkvc_pkg::ST_DUMP_SCAN;
                        end
                    end
                    default: begin
                        if (!i_stat.out_full || i_out_ready) begin
                            n_state = lkvc_pkg::ST_IDLE;
                        end
                    end
                endcase
            end
            lkvc_pkg::ST_EVICT: n_state = lkvc_pkg::ST_WRITE;
            lkvc_pkg::ST_WRITE: n_state = lkvc_pkg::ST_IDLE;
            lkvc_pkg::ST_DUMP_SCAN: begin
                if (i_stat.scan_done) begin
                    n_state = lkvc_pkg::ST_DUMP_EMIT;
                end
            end
            lkvc_pkg::ST_DUMP_EMIT: begin
                if (!i_stat.out_full || i_out_ready) begin
                    n_state = i_stat.more_left ? lkvc_pkg::ST_DUMP_SCAN
                                               : lkvc_pkg::ST_IDLE;
                end
            end
            default: n_state = lkvc_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_ctrl = '0;
        o_ctrl.out_take = w_out_take;
        o_in_ready = 1'b0;
        unique case (r_state)
            lkvc_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                o_ctrl.load = i_in_valid;
            end
            lkvc_pkg::ST_LOOK: begin
                if (i_stat.cmd != lkvc_pkg::CMD_SET
                        && (!i_stat.out_full || i_out_ready)) begin
                    if (i_stat.cmd == lkvc_pkg::CMD_DUMP) begin
                        o_ctrl.look_out = i_stat.empty;
                        o_ctrl.dump_start = !i_stat.empty;
                    end else begin
                        o_ctrl.look_out = 1'b1;
                        o_ctrl.touch = i_stat.hit
                            && (i_stat.cmd == lkvc_pkg::CMD_GET);
                    end
                end
            end
            lkvc_pkg::ST_EVICT: o_ctrl.evict = 1'b1;
            lkvc_pkg::ST_WRITE: o_ctrl.write = 1'b1;
            lkvc_pkg::ST_DUMP_SCAN: o_ctrl.dump_step = 1'b1;
            lkvc_pkg::ST_DUMP_EMIT: begin
                o_ctrl.dump_emit = !i_stat.out_full || i_out_ready;
            end
            default: ;
        endcase
    end

endmodule

// File: src/lkvc_dpath.sv
module lkvc_dpath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [1:0]                        i_cmd,
    input  logic [lkvc_pkg::KeyBits-1:0]      i_key,
    input  logic [lkvc_pkg::ValueBits-1:0]    i_value,
    input  logic [lkvc_pkg::CountBits-1:0]    i_limit,
    input  lkvc_pkg::t_ctrl                   i_ctrl,
    output lkvc_pkg::t_stat                   o_stat,
    output logic                              o_hit,
    output logic [lkvc_pkg::KeyBits-1:0]      o_key,
    output logic [lkvc_pkg::ValueBits-1:0]    o_value,
    output logic                              o_last
);

    localparam int N = lkvc_pkg::Capacity;
    localparam int SB = lkvc_pkg::SlotBits;
    localparam int CB = lkvc_pkg::CountBits;

    logic [lkvc_pkg::KeyBits-1:0]   r_keys [N];
    logic [lkvc_pkg::ValueBits-1:0] r_vals [N];
    logic [N-1:0]                   r_valid;
    logic [SB-1:0]                  r_rank [N];
    logic [CB-1:0]                  r_count;

    logic [1:0]                     r_cmd;
    logic [lkvc_pkg::KeyBits-1:0]   r_key;
    logic [lkvc_pkg::ValueBits-1:0] r_val;
    logic                           r_hit;
    logic [SB-1:0]                  r_slot;

    logic [N-1:0]                   r_sent;
    logic [SB:0]                    r_scan;
    logic                           r_best_ok;
    logic [SB-1:0]                  r_best;
    logic [CB-1:0]                  r_left;

    logic                           r_out_full;
    logic                           r_out_hit;
    logic [lkvc_pkg::KeyBits-1:0]   r_out_key;
    logic [lkvc_pkg::ValueBits-1:0] r_out_val;
    logic                           r_out_last;

    logic [N-1:0]  w_match;
    logic          w_hit;
    logic [SB-1:0] w_slot;
    logic [N-1:0]  w_lru;
    logic [CB-1:0] w_vrank;
    logic [SB-1:0] w_free;
    logic [CB-1:0] w_lim;
    logic          w_over;
    logic [SB-1:0] w_scan_idx;
    logic          w_better;

    // effective bound clamped to the range one to capacity
    assign w_lim = (i_limit == '0) ? CB'(1)
                 : ((i_limit > CB'(N)) ? CB'(N) : i_limit);

    // victim rank: a hit on the least recent slot makes the next oldest the victim
    assign w_vrank = (r_hit && ({1'b0, r_rank[r_slot]} == r_count - CB'(1)))
                   ? (r_count - CB'(2)) : (r_count - CB'(1));

    // parallel compare and priority encode
    always_comb begin
        w_hit = 1'b0;
        w_slot = '0;
        w_free = '0;
        for (int j = N - 1; j >= 0; j--) begin
            w_match[j] = r_valid[j] && (r_keys[j] == r_key);
            w_lru[j] = r_valid[j] && ({1'b0, r_rank[j]} == w_vrank);
            if (w_match[j]) begin
                w_hit = 1'b1;
                w_slot = SB'(j);
            end
            if (!r_valid[j]) begin
                w_free = SB'(j);
            end
        end
    end

    // eviction test before write: hit compares count, miss compares count+1
    assign w_over = r_hit ? (r_count > w_lim) : (r_count >= w_lim);

    assign w_scan_idx = r_scan[SB-1:0];
    assign w_better = r_valid[w_scan_idx] && !r_sent[w_scan_idx]
        && (!r_best_ok || r_keys[w_scan_idx] < r_keys[r_best]);

    // store and recency
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_count <= '0;
            for (int j = 0; j < N; j++) begin
                r_rank[j] <= '0;
            end
        end else begin
            if (i_ctrl.evict && w_over && r_count != '0) begin
                // drop the victim before the write; the hit slot is never the victim
                for (int j = 0; j < N; j++) begin
                    if (w_lru[j]) begin
                        r_valid[j] <= 1'b0;
                        r_rank[j] <= '0;
                    end
                end
                r_count <= r_count - CB'(1);
            end
            if (i_ctrl.write) begin
                if (r_hit) begin
                    r_vals[r_slot] <= r_val;
                    for (int j = 0; j < N; j++) begin
                        if (r_valid[j] && r_rank[j] < r_rank[r_slot]) begin
                            r_rank[j] <= r_rank[j] + SB'(1);
                        end
                    end
                    r_rank[r_slot] <= '0;
                end else begin
                    for (int j = 0; j < N; j++) begin
                        if (r_valid[j]) begin
                            r_rank[j] <= r_rank[j] + SB'(1);
                        end
                    end
                    r_valid[w_free] <= 1'b1;
                    r_keys[w_free] <= r_key;
                    r_vals[w_free] <= r_val;
                    r_rank[w_free] <= '0;
                    r_count <= r_count + CB'(1);
                end
            end
            if (i_ctrl.touch) begin
                for (int j = 0; j < N; j++) begin
                    if (r_valid[j] && r_rank[j] < r_rank[w_slot]) begin
                        r_rank[j] <= r_rank[j] + SB'(1);
                    end
                end
                r_rank[w_slot] <= '0;
            end
        end
    end

    // input capture and lookup result
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_cmd <= i_cmd;
            r_key <= i_key;
            r_val <= i_value;
        end
        if (i_ctrl.dump_start || (i_ctrl.evict == 1'b0 && i_ctrl.write == 1'b0)) begin
            r_hit <= w_hit;
            r_slot <= w_slot;
        end
    end

    // dump scan
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan <= '0;
            r_best_ok <= 1'b0;
        end else if (i_ctrl.dump_start) begin
            r_sent <= '0;
            r_scan <= '0;
            r_best_ok <= 1'b0;
            r_left <= r_count;
        end else if (i_ctrl.dump_step) begin
            if (w_better) begin
                r_best <= w_scan_idx;
                r_best_ok <= 1'b1;
            end
            r_scan <= r_scan + (SB+1)'(1);
        end else if (i_ctrl.dump_emit) begin
            r_sent[r_best] <= 1'b1;
            r_left <= r_left - CB'(1);
            r_scan <= '0;
            r_best_ok <= 1'b0;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_full <= 1'b0;
        end else if (i_ctrl.look_out || i_ctrl.dump_emit) begin
            r_out_full <= 1'b1;
        end else if (i_ctrl.out_take) begin
            r_out_full <= 1'b0;
        end
        if (i_ctrl.look_out) begin
            r_out_last <= 1'b1;
            if (r_cmd == lkvc_pkg::CMD_DUMP) begin
                r_out_hit <= 1'b0;
                r_out_key <= '0;
                r_out_val <= '0;
            end else begin
                r_out_hit <= w_hit;
                r_out_key <= r_key;
                r_out_val <= w_hit ? r_vals[w_slot] : '0;
            end
        end else if (i_ctrl.dump_emit) begin
            r_out_hit <= 1'b1;
            r_out_key <= r_keys[r_best];
            r_out_val <= r_vals[r_best];
            r_out_last <= (r_left == CB'(1));
        end
    end

    always_comb begin
        o_stat.cmd = r_cmd;
        o_stat.hit = w_hit;
        o_stat.scan_done = (r_scan == (SB+1)'(N - 1));
        o_stat.found_any = r_best_ok;
        o_stat.more_left = (r_left != CB'(1));
        o_stat.empty = (r_count == '0);
        o_stat.out_full = r_out_full;
    end

    assign o_hit = r_out_hit;
    assign o_key = r_out_key;
    assign o_value = r_out_val;
    assign o_last = r_out_last;

endmodule

// File: src/lru_key_value_cache.sv
// channel  | dir | handshake          | payload
// s_axis   | in  | tvalid / tready    | tdata: cmd[1:0] key[65:2] value[129:66]
// m_axis   | out | tvalid / tready    | tdata: key_out, value_out; tuser: hit; tlast
// cfg      | in  | valid / ready      | capacity_limit[4:0]
// set passes lookup, evict and write; get and peek pass lookup and wait for output room; dump
// scans again for each emitted word, in key order: one slot compared per cycle in the ordered scan.
// synchronous active-low reset empties the store and sets the bound to 16.
// a full output register stalls the controller; input is taken only when idle.
module lru_key_value_cache (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [135:0]  s_axis_tdata,   // cmd, key, value, zero pad
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [127:0]  m_axis_tdata,   // key_out, value_out
    output logic          m_axis_tuser,   // hit
    output logic          m_axis_tlast,   // last_of_run
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [4:0]    i_cfg_data      // capacity_limit
);

    lkvc_pkg::t_ctrl w_ctrl;
    lkvc_pkg::t_stat w_stat;
    logic [lkvc_pkg::CountBits-1:0] r_limit;
    logic [lkvc_pkg::KeyBits-1:0] w_key;
    logic [lkvc_pkg::ValueBits-1:0] w_val;

    // bound register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= lkvc_pkg::LimitReset;
        end else if (i_cfg_valid) begin
            r_limit <= i_cfg_data;
        end
    end
    assign o_cfg_ready = 1'b1;

    lkvc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_out_ready (m_axis_tready),
        .i_stat      (w_stat),
        .o_ctrl      (w_ctrl)
    );

    lkvc_dpath u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (s_axis_tdata[1:0]),
        .i_key   (s_axis_tdata[65:2]),
        .i_value (s_axis_tdata[129:66]),
        .i_limit (r_limit),
        .i_ctrl  (w_ctrl),
        .o_stat  (w_stat),
        .o_hit   (m_axis_tuser),
        .o_key   (w_key),
        .o_value (w_val),
        .o_last  (m_axis_tlast)
    );

    assign m_axis_tvalid = w_stat.out_full;
    assign m_axis_tdata = {w_val, w_key};

endmodule

// File: test/testbench.sv
`timescale 1ns / 100ps

module testbench;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [63:0] key;
        logic [63:0] value;
    } t_req;

    typedef struct packed {
        logic        hit;
        logic [63:0] key_out;
        logic [63:0] value_out;
        logic        last;
    } t_rsp;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [135:0] s_axis_tdata;    // cmd[1:0], key[65:2], value[129:66], zero pad
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [127:0] m_axis_tdata;    // key_out[63:0], value_out[127:64]
    logic         m_axis_tuser;    // hit
    logic         m_axis_tlast;
    logic         i_cfg_valid;
    logic         o_cfg_ready;
    logic [4:0]   i_cfg_data;      // capacity_limit

    lru_key_value_cache dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    // clock
    always begin
        i_clk = 1'b1; #1;
        i_clk = 1'b0; #1;
    end

    // shadow copy of the store
    logic [63:0] mdl_key [lkvc_pkg::Capacity];
    logic [63:0] mdl_val [lkvc_pkg::Capacity];
    logic        mdl_vld [lkvc_pkg::Capacity];
    int unsigned mdl_rank [lkvc_pkg::Capacity];
    int unsigned mdl_count;
    int unsigned mdl_limit;

    t_req req_queue [$];
    t_rsp rsp_queue [$];
    int   mismatches;
    int   results_seen;
    int   accepted;
    bit   calm;          // no idling near the end
    bit   src_hold;      // sender pause
    int   sink_holdoff;  // long receiver stall, in cycles
    logic [63:0] key_pool [8];

    function automatic int lookup_slot(logic [63:0] k);
        for (int i = 0; i < lkvc_pkg::Capacity; i++)
            if (mdl_vld[i] && mdl_key[i] == k) return i;
        return -1;
    endfunction

    function automatic void promote(int s);
        int unsigned r;
        r = mdl_rank[s];
        for (int j = 0; j < lkvc_pkg::Capacity; j++)
            if (mdl_vld[j] && mdl_rank[j] < r) mdl_rank[j]++;
        mdl_rank[s] = 0;
    endfunction

    function automatic void drop_oldest();
        if (mdl_count == 0) return;
        for (int j = 0; j < lkvc_pkg::Capacity; j++)
            if (mdl_vld[j] && mdl_rank[j] == mdl_count - 1) begin
                mdl_vld[j] = 1'b0;
                mdl_rank[j] = 0;
                mdl_count--;
                return;
            end
    endfunction

    function automatic int unsigned bound_now();
        if (mdl_limit < 1) return 1;
        if (mdl_limit > lkvc_pkg::Capacity) return lkvc_pkg::Capacity;
        return mdl_limit;
    endfunction

    // predict results of one accepted word
    function automatic void predict_cache(t_req r);
        int   s;
        int   best;
        bit   sent [lkvc_pkg::Capacity];
        t_rsp o;
        s = lookup_slot(r.key);
        if (r.cmd == lkvc_pkg::CMD_SET) begin
            if (s >= 0) begin
                mdl_val[s] = r.value;
                promote(s);
                if (mdl_count > bound_now()) drop_oldest();
            end else begin
                if (mdl_count + 1 > bound_now()) drop_oldest();
                s = -1;
                for (int j = 0; j < lkvc_pkg::Capacity; j++)
                    if (!mdl_vld[j] && s < 0) s = j;
                if (s >= 0) begin
                    for (int j = 0; j < lkvc_pkg::Capacity; j++)
                        if (mdl_vld[j]) mdl_rank[j]++;
                    mdl_vld[s] = 1'b1;
                    mdl_key[s] = r.key;
                    mdl_val[s] = r.value;
                    mdl_rank[s] = 0;
                    mdl_count++;
                end
            end
        end else if (r.cmd == lkvc_pkg::CMD_GET || r.cmd == lkvc_pkg::CMD_PEEK) begin
            o.hit = (s >= 0);
            o.key_out = r.key;
            o.value_out = (s >= 0) ? mdl_val[s] : 64'd0;
            o.last = 1'b1;
            rsp_queue.push_back(o);
            if (s >= 0 && r.cmd == lkvc_pkg::CMD_GET) promote(s);
        end else if (mdl_count == 0) begin
            o = '0;
            o.last = 1'b1;
            rsp_queue.push_back(o);
        end else begin
            foreach (sent[j]) sent[j] = 1'b0;
            for (int n = 0; n < mdl_count; n++) begin
                best = -1;
                for (int j = 0; j < lkvc_pkg::Capacity; j++)
                    if (mdl_vld[j] && !sent[j] &&
                        (best < 0 || mdl_key[j] < mdl_key[best])) best = j;
                sent[best] = 1'b1;
                o.hit = 1'b1;
                o.key_out = mdl_key[best];
                o.value_out = mdl_val[best];
                o.last = (n == mdl_count - 1);
                rsp_queue.push_back(o);
            end
        end
    endfunction

    // driver
    int src_gap;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            src_gap = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_cache(req_queue.pop_front());
                accepted++;
            end
            // a word on offer stays until it is taken
            if (!(s_axis_tvalid && !s_axis_tready)) begin
                if (src_gap > 0) src_gap--;
                else if (!calm && $urandom_range(0, 9) == 0) src_gap = $urandom_range(1, 14);
                if (req_queue.size() != 0 && src_gap == 0 && !src_hold) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= {6'd0, req_queue[0].value, req_queue[0].key,
                                     req_queue[0].cmd};
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor and receiver stalls
    int   sink_gap;
    t_rsp got, want;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            sink_gap = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.hit = m_axis_tuser;
                got.key_out = m_axis_tdata[63:0];
                got.value_out = m_axis_tdata[127:64];
                got.last = m_axis_tlast;
                results_seen++;
                if (rsp_queue.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected word: %p", got);
                end else begin
                    want = rsp_queue.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %p got %p", want, got);
                    end
                end
            end
            if (sink_holdoff > 0) begin
                sink_holdoff--;
                m_axis_tready <= 1'b0;
            end else begin
                if (sink_gap > 0) sink_gap--;
                else if (!calm && $urandom_range(0, 9) == 0) sink_gap = $urandom_range(1, 14);
                m_axis_tready <= (sink_gap == 0);
            end
        end
    end

    task automatic push_req(lkvc_pkg::t_cmd c, logic [63:0] k, logic [63:0] v);
        t_req r;
        r.cmd = c;
        r.key = k;
        r.value = v;
        req_queue.push_back(r);
    endtask

    task automatic wait_drained();
        while (req_queue.size() != 0 || s_axis_tvalid || rsp_queue.size() != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_limit(logic [4:0] lim);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= lim;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        mdl_limit = lim;
        @(posedge i_clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // random phase: mostly a small key pool so hits, updates and evictions happen
    task automatic random_batch(int n);
        lkvc_pkg::t_cmd c;
        logic [63:0] k;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: c = lkvc_pkg::CMD_SET;
                4, 5:       c = lkvc_pkg::CMD_GET;
                6, 7:       c = lkvc_pkg::CMD_PEEK;
                default:    c = ($urandom_range(0, 2) == 0) ? lkvc_pkg::CMD_DUMP
                                                            : lkvc_pkg::CMD_GET;
            endcase
            k = ($urandom_range(0, 5) == 0) ? rand64() : key_pool[$urandom_range(0, 7)];
            push_req(c, k, rand64());
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        mismatches = 0;
        results_seen = 0;
        accepted = 0;
        calm = 1'b0;
        src_hold = 1'b0;
        sink_holdoff = 0;
        mdl_count = 0;
        mdl_limit = lkvc_pkg::LimitReset;
        for (int i = 0; i < lkvc_pkg::Capacity; i++) begin
            mdl_vld[i] = 1'b0;
            mdl_rank[i] = 0;
        end
        for (int i = 0; i < 8; i++) key_pool[i] = rand64();
        key_pool[0] = 64'd0;
        key_pool[1] = '1;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty dump, misses, extremes, full store, update
        push_req(lkvc_pkg::CMD_DUMP, 64'd0, 64'd0);
        push_req(lkvc_pkg::CMD_GET, '1, 64'd0);
        push_req(lkvc_pkg::CMD_PEEK, 64'd0, '1);
        push_req(lkvc_pkg::CMD_SET, 64'd0, '1);
        push_req(lkvc_pkg::CMD_SET, '1, 64'd0);
        push_req(lkvc_pkg::CMD_SET, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
        push_req(lkvc_pkg::CMD_GET, 64'd0, 64'd0);
        push_req(lkvc_pkg::CMD_PEEK, '1, 64'd0);
        push_req(lkvc_pkg::CMD_SET, '1, 64'h1234);
        push_req(lkvc_pkg::CMD_DUMP, 64'd0, 64'd0);
        for (int i = 0; i < 15; i++) push_req(lkvc_pkg::CMD_SET, rand64(), rand64());
        push_req(lkvc_pkg::CMD_DUMP, 64'd0, 64'd0);
        wait_drained();

        // lower the bound below the count: evictions one per set
        write_limit(5'd3);
        for (int i = 0; i < 4; i++) push_req(lkvc_pkg::CMD_SET, key_pool[i], rand64());
        push_req(lkvc_pkg::CMD_DUMP, 64'd0, 64'd0);
        wait_drained();

        // bound of zero acts as one
        write_limit(5'd0);
        random_batch(40);
        wait_drained();

        // bound above capacity; long receiver stall while the sender keeps going
        write_limit(5'd31);
        sink_holdoff = 300;
        random_batch(60);
        wait_drained();

        // sender pause until everything has drained
        write_limit(5'd1);
        random_batch(40);
        while (req_queue.size() > 20) @(posedge i_clk);
        src_hold = 1'b1;
        while (rsp_queue.size() != 0 || s_axis_tvalid) @(posedge i_clk);
        src_hold = 1'b0;
        wait_drained();

        write_limit(5'd4);
        random_batch(80);
        wait_drained();

        write_limit(5'd16);
        random_batch(80);
        wait_drained();

        // final stretch without idling
        calm = 1'b1;
        random_batch(40);
        wait_drained();

        $display("covered %0d words in, %0d words out, bounds 0 to 31 incl. eviction and dump",
                 accepted, results_seen);
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("Regression FAIL");
        end
        $finish;
    end

    // timeout
    initial begin
        #4000000;
        $display("timeout");
        $display("Regression FAIL");
        $finish;
    end

endmodule

// File: sim.f
src/lkvc_pkg.sv
src/lkvc_ctrl.sv
src/lkvc_dpath.sv
src/lru_key_value_cache.sv
test/testbench.sv
